>>> rtl/adaptive_slot_tx_decision_assert.svh
// Assertion macros for the slot transmit decision block
`ifndef ADAPTIVE_SLOT_TX_DECISION_ASSERT_SVH
`define ADAPTIVE_SLOT_TX_DECISION_ASSERT_SVH
`ifndef SYNTH
`define ASD_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define ASD_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define ASD_ASSERT_IMP(lbl, clk, rst, a, c)
`define ASD_ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

>>> rtl/asd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package asd_pkg;

   localparam int ROM_ROWS = 16;
   localparam int ROM_COLS = 11;

   typedef enum logic [3:0] {
      S_IDLE, S_PHASE, S_PH_WAIT, S_CH_SETUP, S_CH_WAIT, S_CH_SCAN, S_PROB,
      S_NW_SQ, S_NW_IT, S_NW_WAIT, S_NW_Q, S_NW_QW, S_NW_MUL, S_FIN, S_OUT
   } state_type;

   typedef struct packed {
      logic        start;
      logic [15:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quot;
      logic [15:0] rem;
   } div_rsp_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] value;
   } rom_hit_type;

   localparam logic [7:0] COL_SIZES [ROM_COLS] = '{
      8'd2, 8'd5, 8'd10, 8'd15, 8'd20, 8'd25, 8'd30, 8'd35, 8'd40, 8'd45, 8'd50};

   localparam logic [15:0] PROB_ROM [ROM_ROWS][ROM_COLS] = '{
      '{16'd32768,16'd13107,16'd6554,16'd4369,16'd3277,16'd2621,16'd2185,16'd1872,
        16'd1638,16'd1456,16'd1311},
      '{16'd32768,16'd20323,16'd11685,16'd8120,16'd6210,16'd5025,16'd4219,16'd3635,
        16'd3193,16'd2847,16'd2568},
      '{16'd32768,16'd24087,16'd15575,16'd11289,16'd8812,16'd7216,16'd6105,16'd5289,
        16'd4664,16'd4171,16'd3772},
      '{16'd32768,16'd26214,16'd18488,16'd13936,16'd11102,16'd9201,16'd7847,16'd6836,
        16'd6053,16'd5431,16'd4923},
      '{16'd32768,16'd27538,16'd20681,16'd16136,16'd13107,16'd10994,16'd9450,16'd8279,
        16'd7362,16'd6626,16'd6023},
      '{16'd32768,16'd28430,16'd22356,16'd17964,16'd14857,16'd12607,16'd10923,16'd9623,
        16'd8594,16'd7760,16'd7072},
      '{16'd32768,16'd29067,16'd23659,16'd19488,16'd16384,16'd14055,16'd12272,16'd10872,
        16'd9750,16'd8833,16'd8070},
      '{16'd32768,16'd29544,16'd24693,16'd20766,16'd17716,16'd15356,16'd13506,16'd12032,
        16'd10835,16'd9848,16'd9021},
      '{16'd32768,16'd29913,16'd25528,16'd21845,16'd18881,16'd16523,16'd14635,16'd13107,
        16'd11852,16'd10806,16'd9925},
      '{16'd32768,16'd30207,16'd26214,16'd22763,16'd19904,16'd17571,16'd15668,16'd14103,
        16'd12803,16'd11711,16'd10784},
      '{16'd32768,16'd30447,16'd26786,16'd23551,16'd20804,16'd18514,16'd16612,16'd15026,
        16'd13694,16'd12565,16'd11599},
      '{16'd32768,16'd30645,16'd27269,16'd24232,16'd21600,16'd19364,16'd17476,16'd15881,
        16'd14528,16'd13370,16'd12373},
      '{16'd32768,16'd30813,16'd27683,16'd24825,16'd22307,16'd20131,16'd18268,16'd16674,
        16'd15307,16'd14129,16'd13107},
      '{16'd32768,16'd30956,16'd28039,16'd25346,16'd22937,16'd20826,16'd18994,16'd17409,
        16'd16037,16'd14844,16'd13803},
      '{16'd32768,16'd31080,16'd28351,16'd25806,16'd23502,16'd21456,16'd19661,16'd18091,
        16'd16720,16'd15519,16'd14464},
      '{16'd32768,16'd31188,16'd28624,16'd26214,16'd24009,16'd22030,16'd20274,16'd18724,
        16'd17359,16'd16155,16'd15090}
   };

   // first matching column among the first cols entries of row k-1
   function automatic rom_hit_type rom_lookup(input logic [4:0] k, input logic [7:0] n,
                                              input int cols);
      rom_hit_type r;
      r.hit   = 1'b0;
      r.value = 16'd0;
      if (k >= 5'd1 && k <= 5'(ROM_ROWS)) begin
         for (int j = ROM_COLS - 1; j >= 0; j--) begin
            if (j < cols && COL_SIZES[j] == n) begin
               r.hit   = 1'b1;
               r.value = PROB_ROM[4'(k - 5'd1)][j];
            end
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/asd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// 16-bit restoring divider, one quotient bit per cycle
module asd_div (
   input  wire                  clock,
   input  wire                  reset,
   input  asd_pkg::div_req_type req,
   output asd_pkg::div_rsp_type rsp
);
   logic        busy_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [15:0] rem_ff, quot_ff, dvs_ff;
   logic [16:0] trial;
   logic        fits;

   assign trial = {rem_ff, quot_ff[15]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd16;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff  <= 16'd0;
         quot_ff <= req.dividend;
         dvs_ff  <= req.divisor;
      end else if (busy_ff) begin
         rem_ff  <= fits ? 16'(trial - {1'b0, dvs_ff}) : trial[15:0];
         quot_ff <= {quot_ff[14:0], fits};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;
endmodule
`default_nettype wire

>>> rtl/adaptive_slot_tx_decision.sv
// A start beat or a tick before any start shows its result in the cycle after acceptance.
// A tick takes the table path on a table hit and the square root path otherwise;
// each serial division holds the sequencer until the divider reports done.
// The block takes one beat at a time; req_stall is high from acceptance until the
// result beat is taken. Reset: synchronous, clears round state, channel count 1.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_slot_tx_decision #(
   parameter int CHANNEL_COUNT_MAX = 16,
   parameter int NEWTON_STEPS      = 5,
   parameter int PHASE_LIMIT       = 7,
   parameter int SIZE_COLUMNS      = 11
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_func,
   input  wire  [15:0] req_prob_rand,
   input  wire  [15:0] req_channel_rand,
   // result channel
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_transmit,
   output logic [4:0]  rsp_channel,
   output logic [15:0] rsp_tx_prob,
   output logic [15:0] rsp_slot_index,
   output logic [2:0]  rsp_phase,
   // register port
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [0:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int IW = $clog2(NEWTON_STEPS + 1);

   asd_pkg::state_type state_ff, state_in;

   // register file
   logic [4:0] nch_ff;

   // round state
   logic        started_ff;
   logic [15:0] slot_ff, pend_ff;
   logic [2:0]  phase_ff;
   logic [7:0]  est_ff;

   // per-beat working registers
   logic [15:0] prand_ff, crand_ff;
   logic [4:0]  kk_ff, j_ff;
   logic [15:0] bin_ff;
   logic [20:0] lo_ff;
   logic [3:0]  idx_ff;
   logic [15:0] a_ff, s_ff, c_ff, x_ff, prev_ff, q_ff;
   logic [IW-1:0] i_ff;

   // result registers
   logic        tx_ff;
   logic [4:0]  chan_ff;
   logic [15:0] prob_ff;

   asd_pkg::div_req_type div_req;
   asd_pkg::div_rsp_type div_rsp;
   asd_pkg::rom_hit_type rom;

   logic        req_acc, rsp_acc, ph_cond, nw_stop, scan_end, scan_hit;
   logic [4:0]  kk_sel;
   logic [16:0] xsum;
   logic [15:0] xn;
   logic [15:0] mul_x, mul_y;
   logic [31:0] prod;
   logic [14:0] kn4;

   asd_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // phase boundary test needs the division of the new count by the phase end
   assign ph_cond = (slot_ff != 16'd0) && (pend_ff != 16'd0) && (phase_ff < 3'(PHASE_LIMIT));
   assign kk_sel  = (nch_ff > 5'(CHANNEL_COUNT_MAX)) ? 5'(CHANNEL_COUNT_MAX) : nch_ff;
   assign scan_end = (j_ff >= kk_ff);
   assign scan_hit = ({5'd0, crand_ff} >= lo_ff) && ({5'd0, crand_ff} <= lo_ff + {5'd0, bin_ff});
   assign nw_stop = (i_ff == IW'(NEWTON_STEPS)) || (x_ff == 16'd0);
   assign xsum    = {1'b0, x_ff} + {1'b0, div_rsp.quot};
   assign xn      = xsum[16:1];
   assign rom     = asd_pkg::rom_lookup(nch_ff, est_ff, SIZE_COLUMNS);
   assign kn4     = {13'(nch_ff) * 13'(est_ff), 2'b00};

   // one multiplier: a*a for the discriminant, then (a-x)*q for the result
   assign mul_x = (state_ff == asd_pkg::S_NW_SQ) ? a_ff : 16'(a_ff - x_ff);
   assign mul_y = (state_ff == asd_pkg::S_NW_SQ) ? a_ff : q_ff;
   assign prod  = mul_x * mul_y;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         asd_pkg::S_IDLE:
            if (req_acc) state_in = (req_func && started_ff) ? asd_pkg::S_PHASE
                                                             : asd_pkg::S_OUT;
         asd_pkg::S_PHASE:   state_in = ph_cond ? asd_pkg::S_PH_WAIT : asd_pkg::S_CH_SETUP;
         asd_pkg::S_PH_WAIT: if (div_rsp.done) state_in = asd_pkg::S_CH_SETUP;
         asd_pkg::S_CH_SETUP:
            state_in = (kk_sel == 5'd0) ? asd_pkg::S_PROB : asd_pkg::S_CH_WAIT;
         asd_pkg::S_CH_WAIT:
            if (div_rsp.done)
               state_in = (crand_ff < div_rsp.quot) ? asd_pkg::S_PROB : asd_pkg::S_CH_SCAN;
         asd_pkg::S_CH_SCAN: if (scan_end || scan_hit) state_in = asd_pkg::S_PROB;
         asd_pkg::S_PROB:    state_in = rom.hit ? asd_pkg::S_FIN : asd_pkg::S_NW_SQ;
         asd_pkg::S_NW_SQ:   state_in = asd_pkg::S_NW_IT;
         asd_pkg::S_NW_IT:   state_in = nw_stop ? asd_pkg::S_NW_Q : asd_pkg::S_NW_WAIT;
         asd_pkg::S_NW_WAIT:
            if (div_rsp.done)
               state_in = (i_ff != '0 && prev_ff == xn) ? asd_pkg::S_NW_Q : asd_pkg::S_NW_IT;
         asd_pkg::S_NW_Q:
            state_in = (c_ff == 16'd0) ? asd_pkg::S_NW_MUL : asd_pkg::S_NW_QW;
         asd_pkg::S_NW_QW:   if (div_rsp.done) state_in = asd_pkg::S_NW_MUL;
         asd_pkg::S_NW_MUL:  state_in = asd_pkg::S_FIN;
         asd_pkg::S_FIN:     state_in = asd_pkg::S_OUT;
         asd_pkg::S_OUT:     if (!rsp_stall) state_in = asd_pkg::S_IDLE;
         default:            state_in = asd_pkg::S_IDLE;
      endcase
   end

   // outputs and divider launch
   always_comb begin
      req_stall        = (state_ff != asd_pkg::S_IDLE);
      rsp_valid        = (state_ff == asd_pkg::S_OUT);
      div_req.start    = 1'b0;
      div_req.dividend = 16'hFFFF;
      div_req.divisor  = 16'd1;
      unique case (state_ff)
         asd_pkg::S_PHASE: begin
            div_req.start    = ph_cond;
            div_req.dividend = slot_ff;
            div_req.divisor  = pend_ff;
         end
         asd_pkg::S_CH_SETUP: begin
            div_req.start   = (kk_sel != 5'd0);
            div_req.divisor = {11'd0, kk_sel};
         end
         asd_pkg::S_NW_IT: begin
            div_req.start    = !nw_stop;
            div_req.dividend = s_ff;
            div_req.divisor  = x_ff;
         end
         asd_pkg::S_NW_Q: begin
            div_req.start   = (c_ff != 16'd0);
            div_req.divisor = c_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= asd_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   // register file and round state
   always_ff @(posedge clock) begin
      if (reset) begin
         nch_ff     <= 5'd1;
         started_ff <= 1'b0;
         slot_ff    <= 16'd0;
         phase_ff   <= 3'd1;
         est_ff     <= 8'd2;
         pend_ff    <= 16'd3;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 1'b0)
            nch_ff <= csr_pwdata[4:0];
         if (req_acc) begin
            if (!req_func) begin
               // a start always reopens the round
               started_ff <= 1'b1;
               slot_ff    <= 16'd0;
               phase_ff   <= 3'd1;
               est_ff     <= 8'd2;
               pend_ff    <= 16'd3;
            end else if (started_ff) begin
               slot_ff <= slot_ff + 16'd1;
            end
         end
         if (state_ff == asd_pkg::S_PH_WAIT && div_rsp.done && div_rsp.rem == 16'd0) begin
            phase_ff <= phase_ff + 3'd1;
            est_ff   <= 8'd1 << (phase_ff + 3'd1);
            pend_ff  <= pend_ff + (16'd1 << ({1'b0, phase_ff} + 4'd2));
         end
      end
   end

   // datapath working registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         asd_pkg::S_IDLE: begin
            prand_ff <= req_prob_rand;
            crand_ff <= req_channel_rand;
            tx_ff    <= 1'b0;
            chan_ff  <= 5'd26;
            prob_ff  <= 16'd0;
            idx_ff   <= 4'd0;
         end
         asd_pkg::S_CH_SETUP: kk_ff <= kk_sel;
         asd_pkg::S_CH_WAIT: begin
            bin_ff <= div_rsp.quot;
            lo_ff  <= {5'd0, div_rsp.quot};
            j_ff   <= 5'd1;
         end
         asd_pkg::S_CH_SCAN: begin
            if (!scan_end && scan_hit) idx_ff <= j_ff[3:0];
            j_ff  <= j_ff + 5'd1;
            lo_ff <= lo_ff + {5'd0, bin_ff};
         end
         asd_pkg::S_PROB: begin
            prob_ff <= rom.value;
            a_ff    <= 16'({nch_ff, 1'b0}) + 16'(est_ff) - 16'd1;
            c_ff    <= {7'd0, est_ff, 1'b0};
         end
         asd_pkg::S_NW_SQ: begin
            s_ff    <= prod[15:0] - {1'b0, kn4};
            x_ff    <= 16'd100;
            prev_ff <= 16'd0;
            i_ff    <= '0;
         end
         asd_pkg::S_NW_WAIT:
            if (div_rsp.done) begin
               x_ff    <= xn;
               prev_ff <= xn;
               i_ff    <= i_ff + IW'(1);
            end
         asd_pkg::S_NW_Q:   q_ff <= 16'hFFFF;
         asd_pkg::S_NW_QW:  if (div_rsp.done) q_ff <= div_rsp.quot;
         asd_pkg::S_NW_MUL: prob_ff <= prod[15:0];
         asd_pkg::S_FIN: begin
            tx_ff   <= (prand_ff < prob_ff);
            chan_ff <= 5'd11 + {1'b0, idx_ff};
         end
         default: ;
      endcase
   end

   assign rsp_transmit   = tx_ff;
   assign rsp_channel    = chan_ff;
   assign rsp_tx_prob    = prob_ff;
   assign rsp_slot_index = slot_ff;
   assign rsp_phase      = phase_ff;

   assign csr_prdata = {27'd0, nch_ff};
   assign csr_pready = 1'b1;

`include "adaptive_slot_tx_decision_assert.svh"
   // phase stays within its legal range
   `ASD_ASSERT_IMP(a_phase_range, clock, reset, 1'b1, phase_ff >= 3'd1 && phase_ff <= 3'(PHASE_LIMIT))
   // taken result returns the block to accepting
   `ASD_ASSERT_NXT(a_rsp_done, clock, reset, rsp_acc, !rsp_valid && !req_stall)
   // divider answers only while a wait state expects it
   `ASD_ASSERT_IMP(a_div_wait, clock, reset, div_rsp.done, state_ff == asd_pkg::S_PH_WAIT || state_ff == asd_pkg::S_CH_WAIT || state_ff == asd_pkg::S_NW_WAIT || state_ff == asd_pkg::S_NW_QW)
   // an accepted beat stalls the request side
   `ASD_ASSERT_NXT(a_busy, clock, reset, req_acc, req_stall)
endmodule
`default_nettype wire

>>> tb/sv/adaptive_slot_tx_decision_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module adaptive_slot_tx_decision_tb;

   localparam int CH_MAX      = 16;
   localparam int NW_STEPS    = 5;
   localparam int PH_LIMIT    = 7;
   localparam int SIZE_COLS   = 11;
   localparam int RANDOM_BEATS = 1200;
   localparam int CYCLE_LIMIT = 1500000;
   // register byte address of num_channels_in_use
   localparam logic [0:0] REG_NUM_CHANNELS = 1'b0;
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   typedef struct {
      logic        transmit;
      logic [4:0]  channel;
      logic [15:0] tx_prob;
      logic [15:0] slot_index;
      logic [2:0]  phase;
   } decision_type;

   typedef struct {
      logic         func;
      logic [15:0]  prob_rand;
      logic [15:0]  channel_rand;
      logic         typed;        // expected result typed in below
      decision_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_func;
   logic [15:0] req_prob_rand;
   logic [15:0] req_channel_rand;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_transmit;
   logic [4:0]  rsp_channel;
   logic [15:0] rsp_tx_prob;
   logic [15:0] rsp_slot_index;
   logic [2:0]  rsp_phase;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [0:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   adaptive_slot_tx_decision DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_prob_rand(req_prob_rand), .req_channel_rand(req_channel_rand),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_transmit(rsp_transmit),
      .rsp_channel(rsp_channel), .rsp_tx_prob(rsp_tx_prob),
      .rsp_slot_index(rsp_slot_index), .rsp_phase(rsp_phase),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Predictor state: own copy of round state and channel register
   // ---------------------------------------------------------------
   int unsigned chan_count;
   bit          round_open;
   int unsigned slots;
   int unsigned phase_no;
   int unsigned nbr_est;
   int unsigned phase_stop;

   decision_type decision_q[$];
   int          fail_count;
   bit          stim_done;
   int unsigned cycles;

   function automatic int unsigned channel_index(int unsigned k, int unsigned r);
      int unsigned bin;
      if (k > CH_MAX) k = CH_MAX;
      if (k == 0) return 0;
      bin = 65535 / k;
      if (r < bin) return 0;
      for (int unsigned j = 1; j < k; j++)
         if (r >= j * bin && r <= (j + 1) * bin) return j;
      return 0;   // fell past the last bin
   endfunction

   function automatic int unsigned sqrt_prob(int unsigned k, int unsigned n);
      int unsigned a, s, c, x, prev, q;
      a = (2 * k + n - 1) & 16'hFFFF;
      s = (a * a - 4 * k * n) & 16'hFFFF;
      c = (2 * n) & 16'hFFFF;
      x = 100;
      prev = 0;
      for (int i = 0; i < NW_STEPS; i++) begin
         if (x == 0) break;
         x = ((x + s / x) / 2) & 16'hFFFF;
         if (i > 0 && prev == x) break;
         prev = x;
      end
      q = (c == 0) ? 16'hFFFF : 65535 / c;
      return ((a - x) * q) & 16'hFFFF;
   endfunction

   function automatic int unsigned slot_prob(int unsigned k, int unsigned n);
      int cols;
      cols = (SIZE_COLS > asd_pkg::ROM_COLS) ? asd_pkg::ROM_COLS : SIZE_COLS;
      if (k >= 1 && k <= asd_pkg::ROM_ROWS)
         for (int j = 0; j < cols; j++)
            if (asd_pkg::COL_SIZES[j] == n) return asd_pkg::PROB_ROM[k - 1][j];
      return sqrt_prob(k, n);
   endfunction

   // advance the predictor by one accepted beat
   function automatic decision_type decide_slot(logic func, logic [15:0] prand,
                                                logic [15:0] crand);
      decision_type d;
      int unsigned prob, chan;
      prob = 0;
      chan = 26;
      if (func == FUNC_START) begin
         round_open = 1'b1;
         slots      = 0;
         phase_no   = 1;
         nbr_est    = 2;
         phase_stop = 3;
      end else if (round_open) begin
         slots = (slots + 1) & 16'hFFFF;
         if (slots != 0 && phase_stop != 0 && (slots % phase_stop) == 0 &&
             phase_no < PH_LIMIT) begin
            phase_no   = phase_no + 1;
            nbr_est    = (1 << phase_no) & 8'hFF;
            phase_stop = (phase_stop + (1 << (phase_no + 1))) & 16'hFFFF;
         end
         chan = 11 + channel_index(chan_count, crand);
         prob = slot_prob(chan_count, nbr_est);
      end
      d.transmit   = (func == FUNC_TICK && round_open && prand < prob);
      d.channel    = 5'(chan);
      d.tx_prob    = 16'(prob);
      d.slot_index = 16'(slots);
      d.phase      = 3'(phase_no);
      return d;
   endfunction

   task automatic report(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      fail_count++;
   endtask

   // ---------------------------------------------------------------
   // Directed rows: early rows carry typed-in results (k = 1 after
   // reset, row 0 column 0 gives 32768, a single bin gives channel 11)
   // ---------------------------------------------------------------
   localparam int N_ROWS = 14;
   stim_row_type dir_rows [N_ROWS] = '{
      // tick before any start: nothing moves
      '{FUNC_TICK,  16'h0000, 16'hFFFF, 1'b1, '{1'b0, 5'd26, 16'd0, 16'd0, 3'd1}},
      '{FUNC_START, 16'hFFFF, 16'hFFFF, 1'b1, '{1'b0, 5'd26, 16'd0, 16'd0, 3'd1}},
      '{FUNC_TICK,  16'h0000, 16'h0000, 1'b1, '{1'b1, 5'd11, 16'd32768, 16'd1, 3'd1}},
      '{FUNC_TICK,  16'hFFFF, 16'hFFFF, 1'b1, '{1'b0, 5'd11, 16'd32768, 16'd2, 3'd1}},
      // third tick ends phase 1: estimate 4 takes the square root path
      '{FUNC_TICK,  16'h7FFF, 16'h8000, 1'b0, '{1'b0, 5'd0, 16'd0, 16'd0, 3'd0}},
      '{FUNC_TICK,  16'h8000, 16'h5555, 1'b0, '{1'b0, 5'd0, 16'd0, 16'd0, 3'd0}},
      // restart while a round is running
      '{FUNC_START, 16'h0000, 16'h0000, 1'b1, '{1'b0, 5'd26, 16'd0, 16'd0, 3'd1}},
      '{FUNC_TICK,  16'h7FFF, 16'hAAAA, 1'b1, '{1'b1, 5'd11, 16'd32768, 16'd1, 3'd1}},
      '{FUNC_TICK,  16'h8000, 16'h1234, 1'b1, '{1'b0, 5'd11, 16'd32768, 16'd2, 3'd1}},
      '{FUNC_TICK,  16'hFFFF, 16'h0001, 1'b0, '{1'b0, 5'd0, 16'd0, 16'd0, 3'd0}},
      '{FUNC_TICK,  16'h0001, 16'hFFFE, 1'b0, '{1'b0, 5'd0, 16'd0, 16'd0, 3'd0}},
      '{FUNC_TICK,  16'h00FF, 16'hFF00, 1'b0, '{1'b0, 5'd0, 16'd0, 16'd0, 3'd0}},
      '{FUNC_START, 16'h5A5A, 16'hA5A5, 1'b1, '{1'b0, 5'd26, 16'd0, 16'd0, 3'd1}},
      '{FUNC_TICK,  16'hA5A5, 16'h5A5A, 1'b0, '{1'b0, 5'd0, 16'd0, 16'd0, 3'd0}}
   };

   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   // one beat into the block; predicted at acceptance
   task automatic send_beat(logic func, logic [15:0] prand, logic [15:0] crand,
                            bit typed, decision_type want);
      int gap;
      decision_type d;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_prob_rand    <= prand;
      req_channel_rand <= crand;
      do @(posedge clock); while (req_stall);
      d = decide_slot(func, prand, crand);
      decision_q.push_back(typed ? want : d);
   endtask

   task automatic write_channels(logic [31:0] value);
      @(posedge clock);
      req_valid   <= 1'b0;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_NUM_CHANNELS;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      chan_count  = value & 32'h1F;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (decision_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin
      int unsigned  settings [6];
      decision_type none;
      int           per_setting;
      logic         func;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = FUNC_START;
      req_prob_rand    = '0;
      req_channel_rand = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = REG_NUM_CHANNELS;
      csr_pwdata       = '0;
      fail_count       = 0;
      stim_done        = 1'b0;
      chan_count       = 1;
      round_open       = 1'b0;
      slots            = 0;
      phase_no         = 1;
      nbr_est          = 2;
      phase_stop       = 3;
      none             = '{1'b0, 5'd0, 16'd0, 16'd0, 3'd0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_beat(dir_rows[i].func, dir_rows[i].prob_rand, dir_rows[i].channel_rand,
                   dir_rows[i].typed, dir_rows[i].want);

      // extremes of the channel count, zero and out-of-range codes, then random
      settings = '{16, 0, 31, 1, $urandom_range(15, 2), $urandom_range(31, 17)};
      per_setting = RANDOM_BEATS / 6;
      foreach (settings[s]) begin
         drain();
         write_channels(settings[s]);
         // mostly long rounds so that several phase changes occur
         for (int i = 0; i < per_setting; i++) begin
            func = (i == 0 || $urandom_range(299) == 0) ? FUNC_START : FUNC_TICK;
            send_beat(func, 16'($urandom), 16'($urandom), 1'b0, none);
         end
      end
      @(posedge clock);
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // result side stall: short bursts, occasional long holds, quiet runs
   initial begin
      int hold;
      bit level;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else begin
            level = ($urandom_range(99) < 30);
            hold  = ($urandom_range(19) == 0) ? $urandom_range(50, 10) : $urandom_range(3);
            rsp_stall <= level;
         end
      end
   end

   // result checker: compare each taken beat with the oldest prediction
   always @(posedge clock) begin
      decision_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decision_q.size() == 0) begin
            report("result beat with no prediction waiting");
         end else begin
            w = decision_q.pop_front();
            if (rsp_transmit !== w.transmit || rsp_channel !== w.channel ||
                rsp_tx_prob !== w.tx_prob || rsp_slot_index !== w.slot_index ||
                rsp_phase !== w.phase)
               report($sformatf("got tx=%0d ch=%0d p=%0d slot=%0d ph=%0d, want %0d %0d %0d %0d %0d",
                  rsp_transmit, rsp_channel, rsp_tx_prob, rsp_slot_index, rsp_phase,
                  w.transmit, w.channel, w.tx_prob, w.slot_index, w.phase));
         end
      end
   end

   // end of run and watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
         if (stim_done && decision_q.size() == 0) begin
            repeat (250) @(posedge clock);
            if (fail_count == 0 && decision_q.size() == 0) begin
               $display("Test completed successfully");
            end else begin
               $display("Test completed with failures");
            end
            $finish;
         end
      end
   end

endmodule
`default_nettype wire
